FILE: src/tdf_pkg.sv
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared types and constants for the factorizer and its divider.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // Status that the shared divider reports to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

  // First trial divisor.
  localparam int unsigned FIRST_DIVISOR = 2;

  // Smallest value that has a prime factor.
  localparam int unsigned MIN_FACTORABLE = 2;

endpackage

FILE: src/tdf_in_if.sv
// ----------------------------------------------------------------------------
// Factorizer operand channel
// Valid/ready channel that carries one value to be factorized per request.
// ----------------------------------------------------------------------------
interface tdf_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: src/tdf_out_if.sv
// ----------------------------------------------------------------------------
// Factorizer result channel
// Valid/ready channel carrying one prime factor or empty result per request.
// ----------------------------------------------------------------------------
interface tdf_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] factor;
  logic                   empty_res;
  logic                   last;

  modport source (output valid, output factor, output empty_res, output last, input ready);
  modport sink   (input valid, input factor, input empty_res, input last, output ready);
endinterface

FILE: src/tdf_divider.sv
// ----------------------------------------------------------------------------
// Trial division factorizer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output tdf_pkg::div_status_t   status
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   take;
  logic [VALUE_WIDTH-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[VALUE_WIDTH-1]};
    diff     = trial - {1'b0, divisor};
    take     = trial >= {1'b0, divisor};
    rem_next = take ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      cnt <= CNT_W'(VALUE_WIDTH - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[VALUE_WIDTH-2:0], take};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient        = quo;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

FILE: src/trial_division_factorizer.sv
// Each trial division on the shared divider runs a start, one quotient step per
// dividend bit and a decision; each emitted factor passes through the emit state.
// A prime near the top of the range needs about 2^(VALUE_WIDTH/2) trials.
// Values 0 and 1 go from idle straight to emit and give a single empty result.
// One item at a time; a new one is taken while the last result still waits.
// Synchronous reset returns the sequencer to idle and drops the result valid.
// ----------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factors of each value in ascending order, one per request.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  tdf_in_if.sink    operand,
  tdf_out_if.source factors
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] q;
  logic [VALUE_WIDTH-1:0] d;
  logic                   check;
  logic [VALUE_WIDTH-1:0] res_factor;
  logic                   res_empty;
  logic                   res_last;
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_factor;
  logic                   out_empty;
  logic                   out_last;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] quo;
  tdf_pkg::div_status_t   div_status;
  logic                   accept;
  logic                   load_out;

  tdf_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q),
    .divisor  (d),
    .quotient (quo),
    .status   (div_status)
  );

  assign operand.ready = (state == S_IDLE);
  assign accept        = operand.valid && operand.ready;
  assign div_start     = (state == S_START);
  assign load_out      = (state == S_EMIT) && (!out_valid || factors.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operand.value < VALUE_WIDTH'(tdf_pkg::MIN_FACTORABLE)) begin
              state <= S_EMIT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_status.done) begin
            if ((check && d > quo) || div_status.rem_zero) begin
              state <= S_EMIT;
            end else begin
              state <= S_START;
            end
          end
        end
        default: begin
          if (load_out) begin
            state <= res_last ? S_IDLE : S_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          q          <= operand.value;
          d          <= VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);
          check      <= 1'b1;
          res_factor <= '0;
          res_empty  <= 1'b1;
          res_last   <= 1'b1;
        end
      end
      S_WAIT: begin
        if (div_status.done) begin
          res_empty <= 1'b0;
          priority if (check && d > quo) begin
            res_factor <= q;
            res_last   <= 1'b1;
          end else if (div_status.rem_zero) begin
            res_factor <= d;
            res_last   <= (quo == VALUE_WIDTH'(1));
            q          <= quo;
            check      <= 1'b0;
          end else begin
            d     <= d + 1'b1;
            check <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (factors.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_factor <= res_factor;
      out_empty  <= res_empty;
      out_last   <= res_last;
    end
  end

  assign factors.valid     = out_valid;
  assign factors.factor    = out_factor;
  assign factors.empty_res = out_empty;
  assign factors.last      = out_last;

endmodule

FILE: verif/tdf_factor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Factorizer result checker
// Watches the operand and result channels, works out the prime factors of
// each accepted value and compares every accepted result with them in order.
// ----------------------------------------------------------------------------
module tdf_factor_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  tdf_in_if           operand,
  tdf_out_if          factors,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] factor;
    logic                   empty_res;
    logic                   last;
  } factor_rec_t;

  factor_rec_t factors_due [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: factor mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void factorize(input logic [VALUE_WIDTH-1:0] value);
    logic [63:0] rest;
    logic [63:0] div;
    factor_rec_t rec;
    if (value < tdf_pkg::MIN_FACTORABLE) begin
      rec = '{factor: '0, empty_res: 1'b1, last: 1'b1};
      factors_due.insert(factors_due.size(), rec);
      return;
    end
    rest = 64'(value);
    div  = 64'(tdf_pkg::FIRST_DIVISOR);
    while (div <= rest / div) begin
      while (rest % div == 0) begin
        rest = rest / div;
        rec  = '{factor: div[VALUE_WIDTH-1:0], empty_res: 1'b0, last: (rest == 1)};
        factors_due.insert(factors_due.size(), rec);
      end
      div++;
    end
    if (rest > 1) begin
      rec = '{factor: rest[VALUE_WIDTH-1:0], empty_res: 1'b0, last: 1'b1};
      factors_due.insert(factors_due.size(), rec);
    end
  endfunction

  always @(posedge clk) begin
    factor_rec_t got;
    factor_rec_t want;
    if (!rst) begin
      if (operand.valid && operand.ready) begin
        factorize(operand.value);
      end
      if (factors.valid && factors.ready) begin
        got = '{factor: factors.factor, empty_res: factors.empty_res, last: factors.last};
        if (factors_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result factor=%0d empty_res=%b last=%b",
                                    got.factor, got.empty_res, got.last));
        end else begin
          want = factors_due.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf("factor=%0d empty_res=%b last=%b, wanted %0d %b %b",
                                      got.factor, got.empty_res, got.last,
                                      want.factor, want.empty_res, want.last));
          end
        end
      end
      pending <= factors_due.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial division factorizer testbench
// Sends corner values and then random values built mostly from small factors,
// with random gaps and result stalls; the checker compares every factor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VALUE_WIDTH = 32;
  localparam int unsigned RANDOM_COUNT = 80;
  localparam int unsigned TAIL_CYCLES = 8 * (VALUE_WIDTH + 3);

  logic        clk;
  logic        rst;
  bit          calm;
  int unsigned fail_count;
  int unsigned pending;

  logic [VALUE_WIDTH-1:0] corner_values [$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd49, 32'd64, 32'd30030,
    32'd65521, 32'd65535, 32'd65537, 32'd1000000, 32'd16777213,
    32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd3486784401, 32'd4294836225
  };

  tdf_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) operand ();
  tdf_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) factors ();

  trial_division_factorizer #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .factors (factors)
  );

  tdf_factor_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .operand    (operand),
    .factors    (factors),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      factors.ready <= 1'b0;
    end else begin
      factors.ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  // Most values are products of small factors so that the trial loop stays
  // short; a few reach a medium prime range.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [63:0] acc;
    logic [63:0] mult;
    bit          done;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      return VALUE_WIDTH'($urandom_range(0, 3));
    end
    if (kind < 15) begin
      return VALUE_WIDTH'($urandom_range(2, 1 << 20));
    end
    acc  = ($urandom_range(0, 3) == 0) ? 64'd1 : 64'($urandom_range(2, 40000));
    done = 1'b0;
    while (!done) begin
      mult = 64'($urandom_range(2, 200));
      if (acc * mult > 64'hFFFF_FFFF) begin
        done = 1'b1;
      end else begin
        acc  = acc * mult;
        done = ($urandom_range(0, 11) == 0);
      end
    end
    return acc[VALUE_WIDTH-1:0];
  endfunction

  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    if (!calm && $urandom_range(0, 99) < 27) begin
      operand.valid <= 1'b0;
      operand.value <= VALUE_WIDTH'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < 27);
    end
    operand.valid <= 1'b1;
    operand.value <= value;
    do @(posedge clk); while (!operand.ready);
  endtask

  task automatic wait_all_factors();
    operand.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    calm          = 1'b0;
    operand.valid = 1'b0;
    operand.value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end
    wait_all_factors();
    for (int unsigned n = 0; n < RANDOM_COUNT; n++) begin
      calm <= (n >= 40 && n < 70);
      send_value(pick_value());
    end
    wait_all_factors();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tdf_pkg.sv
src/tdf_in_if.sv
src/tdf_out_if.sv
src/tdf_divider.sv
src/trial_division_factorizer.sv
verif/tdf_factor_checker.sv
verif/tb_top.sv
